// ===== hdl/gbe_pkg.sv =====
// shared types and constants for the glyph bitmap expander
package gbe_pkg;

	localparam int DEF_MAX_GLYPH_DIM = 76;
	localparam int COLOR_W = 16;
	localparam int DIM_W = 7;
	localparam int BYTE_CNT_W = 4;
	localparam int PIX_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FG_COLOR = 2'd0,
		REG_BG_COLOR = 2'd1,
		REG_GLYPH_WIDTH = 2'd2,
		REG_GLYPH_HEIGHT = 2'd3
	} gbe_reg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [PIX_IDX_W-1:0] last_col;
		logic glyph_end;
	} gbe_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} gbe_qstat_t;

endpackage

// ===== hdl/gbe_front.sv =====
// front end: accepts bitmap bytes, tracks byte and row position, classifies each byte
module gbe_front import gbe_pkg::*; #(
	parameter int MAX_GLYPH_DIM = DEF_MAX_GLYPH_DIM
) (
	input  logic clk,
	input  logic arst_n,
	input  logic glyph_valid,
	output logic glyph_stall,
	input  logic [7:0] glyph_byte,
	input  logic [DIM_W-1:0] glyph_width,
	input  logic [DIM_W-1:0] glyph_height,
	input  gbe_qstat_t qstat,
	output logic push,
	output gbe_cmd_t push_cmd
);

	logic [BYTE_CNT_W-1:0] byte_in_row_q;
	logic [DIM_W-1:0] row_index_q;
	logic [DIM_W-1:0] w_m1;
	logic [DIM_W-1:0] h_m1;
	logic [BYTE_CNT_W-1:0] bpr_m1;
	logic last_byte;
	logic last_row;

	function automatic logic [DIM_W-1:0] clamp_m1(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if ({1'b0, v} > (DIM_W+1)'(MAX_GLYPH_DIM)) begin
			r = DIM_W'(MAX_GLYPH_DIM - 1);
		end else begin
			r = v - DIM_W'(1);
		end
		return r;
	endfunction

	always_comb begin
		w_m1 = clamp_m1(glyph_width);
		h_m1 = clamp_m1(glyph_height);
		bpr_m1 = BYTE_CNT_W'(w_m1 >> 3);
		last_byte = (byte_in_row_q >= bpr_m1);
		last_row = (row_index_q >= h_m1);
		glyph_stall = qstat.full;
		push = glyph_valid && !qstat.full;
		push_cmd.data = glyph_byte;
		push_cmd.last_col = last_byte ? w_m1[PIX_IDX_W-1:0] : '1;
		push_cmd.glyph_end = last_byte && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			row_index_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				byte_in_row_q <= '0;
				row_index_q <= last_row ? '0 : row_index_q + DIM_W'(1);
			end else begin
				byte_in_row_q <= byte_in_row_q + BYTE_CNT_W'(1);
				row_index_q <= last_row ? h_m1 : row_index_q;
			end
		end
	end

endmodule

// ===== hdl/gbe_queue.sv =====
// two-entry queue between front and back end
module gbe_queue import gbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  gbe_cmd_t push_cmd,
	input  logic pop,
	output gbe_qstat_t qstat,
	output gbe_cmd_t head_cmd
);

	gbe_cmd_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_comb begin
		qstat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
		qstat.empty = (count_q == '0);
		head_cmd = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/gbe_back.sv =====
// back end: walks the pixels of the head byte and drives the registered pixel output
module gbe_back import gbe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [COLOR_W-1:0] fg_color,
	input  logic [COLOR_W-1:0] bgnd_color,
	input  gbe_qstat_t qstat,
	input  gbe_cmd_t head_cmd,
	output logic pop,
	output logic pixel_valid,
	input  logic pixel_stall,
	output logic [COLOR_W-1:0] pixel_rgb,
	output logic last_of_byte,
	output logic last_of_glyph
);

	logic [PIX_IDX_W-1:0] col_q;
	logic out_valid_q;
	logic [COLOR_W-1:0] color_q;
	logic lob_q;
	logic log_q;
	logic load;
	logic emit;
	logic bit_set;
	logic end_col;

	always_comb begin
		load = !out_valid_q || !pixel_stall;
		emit = load && !qstat.empty;
		bit_set = head_cmd.data[PIX_IDX_W'(7) - col_q];
		end_col = (col_q == head_cmd.last_col);
		pop = emit && end_col;
		pixel_valid = out_valid_q;
		pixel_rgb = color_q;
		last_of_byte = lob_q;
		last_of_glyph = log_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !qstat.empty;
			end
			if (emit) begin
				col_q <= end_col ? '0 : col_q + PIX_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			color_q <= bit_set ? fg_color : bgnd_color;
			lob_q <= end_col;
			log_q <= end_col && head_cmd.glyph_end;
		end
	end

endmodule

// ===== hdl/glyph_bitmap_to_rgb565_expander.sv =====
// top level of the glyph bitmap to rgb565 expander
//
//   channel   direction  handshake                     payload
//   glyph     in         glyph_valid / glyph_stall     glyph_byte
//   pixel     out        pixel_valid / pixel_stall     pixel_rgb, last_of_byte, last_of_glyph
//   config    in         apb psel/penable/pready       paddr, pwdata, prdata
//
// one pixel leaves per cycle while pixel_stall is low and the queue holds a byte;
// a byte gives 1 to 8 pixels, one per column it covers; the pixel walker in the back end
// sets the rate; the front takes a byte per cycle until the two-entry queue is full
// a byte is written into the queue first, then its first pixel into the output register
// reset clears counters, queue and output valid; registers return to their defaults
// pixel_stall holds the output register; glyph_stall rises only when the queue is full
module glyph_bitmap_to_rgb565_expander import gbe_pkg::*; #(
	parameter int MAX_GLYPH_DIM = DEF_MAX_GLYPH_DIM
) (
	input  logic clk,
	input  logic arst_n,
	input  logic glyph_valid,
	output logic glyph_stall,
	input  logic [7:0] glyph_byte,
	output logic pixel_valid,
	input  logic pixel_stall,
	output logic [COLOR_W-1:0] pixel_rgb,
	output logic last_of_byte,
	output logic last_of_glyph,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	logic [COLOR_W-1:0] fg_color_q;
	logic [COLOR_W-1:0] bg_color_q;
	logic [DIM_W-1:0] glyph_width_q;
	logic [DIM_W-1:0] glyph_height_q;
	logic cfg_wr;
	gbe_reg_t reg_sel;
	gbe_qstat_t qstat;
	gbe_cmd_t push_cmd;
	gbe_cmd_t head_cmd;
	logic push;
	logic pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = gbe_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= '1;
			bg_color_q <= '0;
			glyph_width_q <= DIM_W'(8);
			glyph_height_q <= DIM_W'(16);
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_FG_COLOR: fg_color_q <= pwdata[COLOR_W-1:0];
				REG_BG_COLOR: bg_color_q <= pwdata[COLOR_W-1:0];
				REG_GLYPH_WIDTH: glyph_width_q <= pwdata[DIM_W-1:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FG_COLOR: prdata = APB_DATA_W'(fg_color_q);
			REG_BG_COLOR: prdata = APB_DATA_W'(bg_color_q);
			REG_GLYPH_WIDTH: prdata = APB_DATA_W'(glyph_width_q);
			REG_GLYPH_HEIGHT: prdata = APB_DATA_W'(glyph_height_q);
			default: prdata = '0;
		endcase
	end

	gbe_front #(
		.MAX_GLYPH_DIM(MAX_GLYPH_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.glyph_valid(glyph_valid),
		.glyph_stall(glyph_stall),
		.glyph_byte(glyph_byte),
		.glyph_width(glyph_width_q),
		.glyph_height(glyph_height_q),
		.qstat(qstat),
		.push(push),
		.push_cmd(push_cmd)
	);

	gbe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.qstat(qstat),
		.head_cmd(head_cmd)
	);

	gbe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fg_color(fg_color_q),
		.bgnd_color(bg_color_q),
		.qstat(qstat),
		.head_cmd(head_cmd),
		.pop(pop),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_rgb(pixel_rgb),
		.last_of_byte(last_of_byte),
		.last_of_glyph(last_of_glyph)
	);

endmodule

// ===== hdl/gbe_checker.sv =====
// port-level checks for the glyph bitmap expander and their binding
module gbe_checker import gbe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pixel_valid,
	input logic pixel_stall,
	input logic [COLOR_W-1:0] pixel_rgb,
	input logic last_of_byte,
	input logic last_of_glyph
);

	// glyph end is always a byte end
	a_glyph_end_is_byte_end: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> (!last_of_glyph || last_of_byte))
		else $error("last_of_glyph without last_of_byte");

	// a byte with pixels left keeps the output busy the next cycle
	a_byte_pixels_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall && !last_of_byte) |=> pixel_valid)
		else $error("gap inside the pixels of one byte");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_stall) |=> pixel_valid)
		else $error("pixel_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_stall) |=>
			($stable(pixel_rgb) && $stable(last_of_byte) && $stable(last_of_glyph)))
		else $error("pixel payload changed while stalled");

endmodule

bind glyph_bitmap_to_rgb565_expander gbe_checker u_gbe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pixel_valid(pixel_valid),
	.pixel_stall(pixel_stall),
	.pixel_rgb(pixel_rgb),
	.last_of_byte(last_of_byte),
	.last_of_glyph(last_of_glyph)
);
